>>> hdl/afd_pkg.sv
// Shared types, constants and helpers of the allele frequency distance block.
package afd_pkg;

    localparam int ORG_W      = 6;
    localparam int SITE_W     = 10;
    localparam int ADDR_W     = ORG_W + SITE_W;
    localparam int MAX_ORGS   = 64;
    localparam int MAX_SITES  = 1024;
    localparam int MEM_DEPTH  = 1 << ADDR_W;
    localparam int COUNT_BITS = 8;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_STATES = 5;
    localparam int ST_W       = 3;
    localparam int TOTAL_W    = 11;
    localparam int DIVD_W     = COUNT_BITS + FRAC_BITS;
    localparam int FREQ_W     = FRAC_BITS + 1;
    localparam int PROD_W     = 2 * FREQ_W;
    localparam int NSUM_W     = FREQ_W + 3;
    localparam int ACC_W      = 48;
    localparam int ROOT_W     = ACC_W / 2;
    localparam int DIST_W     = 24;
    localparam int NORG_W     = 7;
    localparam int NPOS_W     = 11;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_METHOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ORG = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POS = 2'd3;

    localparam logic [7:0] CHAR_A   = 8'h41;
    localparam logic [7:0] CHAR_C   = 8'h43;
    localparam logic [7:0] CHAR_T   = 8'h54;
    localparam logic [7:0] CHAR_G   = 8'h47;
    localparam logic [7:0] CHAR_GAP = 8'h2D;

    typedef struct packed {
        op_t              op;
        logic [ORG_W-1:0] org_a;
        logic [ORG_W-1:0] org_b;
        logic [SITE_W-1:0] site;
        logic [7:0]       base;
    } in_beat_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              org_missing;
    } out_beat_t;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef count_t [NUM_STATES-1:0] count_word_t;
    typedef logic [FREQ_W-1:0] freq_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        count_word_t       wr_data;
    } mem_req_t;

    typedef struct packed {
        logic            hit;
        logic [ST_W-1:0] idx;
    } base_code_t;

    function automatic base_code_t base_code(input logic [7:0] ch);
        base_code_t bc;
        bc.hit = 1'b1;
        bc.idx = '0;
        unique case (ch)
            CHAR_A:   bc.idx = 3'd0;
            CHAR_C:   bc.idx = 3'd1;
            CHAR_T:   bc.idx = 3'd2;
            CHAR_G:   bc.idx = 3'd3;
            CHAR_GAP: bc.idx = 3'd4;
            default:  bc.hit = 1'b0;
        endcase
        return bc;
    endfunction

endpackage

>>> hdl/afd_count_mem.sv
// Count memory: one word of five state counts per organism and site.
module afd_count_mem (
    input  logic                 aclk,
    input  afd_pkg::mem_req_t    req,
    output afd_pkg::count_word_t rd_a,
    output afd_pkg::count_word_t rd_b
);

    afd_pkg::count_word_t mem [afd_pkg::MEM_DEPTH];
    afd_pkg::count_word_t rd_a_reg;
    afd_pkg::count_word_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_a_reg <= mem[req.rd_addr_a];
            rd_b_reg <= mem[req.rd_addr_b];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

>>> hdl/afd_freq_div.sv
// Ten-lane restoring divider for the relative frequencies of two count words.
module afd_freq_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic                 ignore_missing,
    input  afd_pkg::count_word_t cnt_a,
    input  afd_pkg::count_word_t cnt_b,
    output logic                 busy,
    output afd_pkg::freq_t       freq_a [afd_pkg::NUM_STATES],
    output afd_pkg::freq_t       freq_b [afd_pkg::NUM_STATES]
);

    localparam int NS = afd_pkg::NUM_STATES;
    localparam int TW = afd_pkg::TOTAL_W;
    localparam int DW = afd_pkg::DIVD_W;
    localparam int FW = afd_pkg::FREQ_W;
    localparam logic [4:0] LAST_STEP = 5'(DW - 1);

    logic                  busy_reg;
    logic [4:0]            step_reg;
    logic                  ign_reg;
    logic [TW-1:0]         div_reg [2];
    logic [TW-1:0]         rem_reg [2][NS];
    logic [DW-1:0]         quo_reg [2][NS];

    afd_pkg::count_word_t  cnt_in [2];
    logic [TW-1:0]         tot [2];
    logic [TW-1:0]         rem_next [2][NS];
    logic [DW-1:0]         quo_next [2][NS];
    afd_pkg::freq_t        freq [2][NS];

    assign cnt_in[0] = cnt_a;
    assign cnt_in[1] = cnt_b;

    always_comb begin
        logic [TW:0] trial;
        logic        ge;
        for (int l = 0; l < 2; l++) begin
            tot[l] = '0;
            for (int s = 0; s < NS; s++) begin
                if (s < NS - 1 || !ignore_missing) begin
                    tot[l] = tot[l] + TW'(cnt_in[l][s]);
                end
            end
            for (int s = 0; s < NS; s++) begin
                trial = {rem_reg[l][s], quo_reg[l][s][DW-1]};
                ge = (trial >= {1'b0, div_reg[l]});
                if (ge) begin
                    rem_next[l][s] = TW'(trial - {1'b0, div_reg[l]});
                end else begin
                    rem_next[l][s] = trial[TW-1:0];
                end
                quo_next[l][s] = {quo_reg[l][s][DW-2:0], ge};
                if (div_reg[l] != '0 && (s < NS - 1 || !ign_reg)) begin
                    freq[l][s] = quo_reg[l][s][FW-1:0];
                end else begin
                    freq[l][s] = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 5'd1;
            if (step_reg == LAST_STEP) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ign_reg <= ignore_missing;
            for (int l = 0; l < 2; l++) begin
                div_reg[l] <= tot[l];
                for (int s = 0; s < NS; s++) begin
                    rem_reg[l][s] <= '0;
                    quo_reg[l][s] <= {cnt_in[l][s], {afd_pkg::FRAC_BITS{1'b0}}};
                end
            end
        end else if (busy_reg) begin
            for (int l = 0; l < 2; l++) begin
                for (int s = 0; s < NS; s++) begin
                    rem_reg[l][s] <= rem_next[l][s];
                    quo_reg[l][s] <= quo_next[l][s];
                end
            end
        end
    end

    assign busy = busy_reg;

    always_comb begin
        for (int s = 0; s < NS; s++) begin
            freq_a[s] = freq[0][s];
            freq_b[s] = freq[1][s];
        end
    end

endmodule

>>> hdl/afd_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module afd_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [afd_pkg::ACC_W-1:0]   radicand,
    output logic                        busy,
    output logic [afd_pkg::ROOT_W-1:0]  root
);

    localparam int AW = afd_pkg::ACC_W;

    logic          busy_reg;
    logic [AW-1:0] x_reg;
    logic [AW-1:0] r_reg;
    logic [AW-1:0] bit_reg;
    logic [AW:0]   trial;

    assign trial = {1'b0, r_reg} + {1'b0, bit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && bit_reg[0]) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= AW'(1) << (AW - 2);
        end else if (busy_reg) begin
            if ({1'b0, x_reg} >= trial) begin
                x_reg <= x_reg - trial[AW-1:0];
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = r_reg[afd_pkg::ROOT_W-1:0];

endmodule

>>> hdl/allele_frequency_distance.sv
// Top level: allele count store with Euclidean and Nei pair distance queries.
//
// Input beats on s_valid/s_ready carry an op: add one base of an organism at a
// site, query the distance of two organisms, or clear all counts. A result
// beat leaves on m_valid/m_ready for each query only. Configuration writes on
// cfg_valid/cfg_ready (always ready) set method, gap handling, organism count
// and site count; write them only while the block is idle.
// An add reads and writes back one count word of the memory.
// A clear, and reset, sweep the count memory one word a cycle with s_ready
// low. A query walks sites serially through the one count memory, the
// frequency divider lanes and, per base state (4 or 5 per site), either
// a multiply-accumulate (Euclidean) or a multiply and square root (Nei),
// then a final root (Euclidean) or divide by the site count (Nei). Queries
// naming a missing or identical organism skip the site walk. A result waits
// in the output register while the receiver stalls; adds and clears are
// still taken meanwhile, a further query stalls at its end until the output
// register is free.
module allele_frequency_distance (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  afd_pkg::in_beat_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output afd_pkg::out_beat_t                m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [afd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [afd_pkg::NPOS_W-1:0]        cfg_data
);

    localparam int AW  = afd_pkg::ACC_W;
    localparam int FW  = afd_pkg::FREQ_W;
    localparam int NSW = afd_pkg::NSUM_W;
    localparam logic [NSW-1:0] NEI_ONE = NSW'(1) << afd_pkg::FRAC_BITS;
    localparam logic [5:0] FD_LAST = 6'(AW);

    typedef enum logic [15:0] {
        S_CLEAR  = 16'h0001,
        S_IDLE   = 16'h0002,
        S_ADD_WR = 16'h0004,
        S_Q_RD   = 16'h0008,
        S_Q_LOAD = 16'h0010,
        S_Q_DIV  = 16'h0020,
        S_E_DIF  = 16'h0040,
        S_E_MUL  = 16'h0080,
        S_E_ACC  = 16'h0100,
        S_N_MUL  = 16'h0200,
        S_N_SQS  = 16'h0400,
        S_N_SQW  = 16'h0800,
        S_N_ACC  = 16'h1000,
        S_FIN    = 16'h2000,
        S_FIN_W  = 16'h4000,
        S_OUT    = 16'h8000
    } state_t;

    state_t                              state_reg;
    logic                                method_reg;
    logic                                ign_reg;
    logic [afd_pkg::NORG_W-1:0]          norg_reg;
    logic [afd_pkg::NPOS_W-1:0]          npos_reg;
    logic [afd_pkg::MAX_ORGS-1:0]        present_reg;
    logic [afd_pkg::ADDR_W-1:0]          clr_addr_reg;
    logic [afd_pkg::ADDR_W-1:0]          add_addr_reg;
    logic [afd_pkg::ST_W-1:0]            add_idx_reg;
    logic [afd_pkg::ORG_W-1:0]           qa_reg;
    logic [afd_pkg::ORG_W-1:0]           qb_reg;
    logic [afd_pkg::SITE_W-1:0]          site_reg;
    logic [afd_pkg::ST_W-1:0]            z_reg;
    logic [FW-1:0]                       diff_reg;
    logic [afd_pkg::PROD_W-1:0]          prod_reg;
    logic [NSW-1:0]                      nsum_reg;
    logic [AW-1:0]                       acc_reg;
    logic [afd_pkg::TOTAL_W-1:0]         fd_rem_reg;
    logic [AW-1:0]                       fd_quo_reg;
    logic [5:0]                          fd_step_reg;
    logic [afd_pkg::DIST_W-1:0]          res_dist_reg;
    logic                                res_miss_reg;
    logic                                m_valid_reg;
    afd_pkg::out_beat_t                  m_data_reg;

    logic                                s_fire;
    logic                                out_load;
    afd_pkg::base_code_t                 bcode;
    afd_pkg::mem_req_t                   mem_req;
    afd_pkg::count_word_t                rd_a;
    afd_pkg::count_word_t                rd_b;
    afd_pkg::count_word_t                inc_word;
    afd_pkg::freq_t                      fa [afd_pkg::NUM_STATES];
    afd_pkg::freq_t                      fb [afd_pkg::NUM_STATES];
    logic                                fd_busy;
    logic                                iq_start;
    logic [AW-1:0]                       iq_rad;
    logic                                iq_busy;
    logic [afd_pkg::ROOT_W-1:0]          iq_root;
    logic [afd_pkg::NORG_W-1:0]          norg_eff;
    logic [afd_pkg::NPOS_W-1:0]          npos_eff;
    logic [afd_pkg::ST_W-1:0]            nst;
    logic                                site_last;
    logic                                z_last;
    logic [afd_pkg::TOTAL_W:0]           fd_trial;
    logic                                fd_ge;
    logic [FW-1:0]                       nei_term;

    function automatic logic [AW-1:0] acc_add(input logic [AW-1:0] a,
                                              input logic [AW-1:0] v);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, v};
        return s[AW] ? {AW{1'b1}} : s[AW-1:0];
    endfunction

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign bcode     = afd_pkg::base_code(s_data.base);
    assign out_load  = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    assign norg_eff = (norg_reg > afd_pkg::NORG_W'(afd_pkg::MAX_ORGS)) ?
                      afd_pkg::NORG_W'(afd_pkg::MAX_ORGS) : norg_reg;
    assign npos_eff = (npos_reg > afd_pkg::NPOS_W'(afd_pkg::MAX_SITES)) ?
                      afd_pkg::NPOS_W'(afd_pkg::MAX_SITES) : npos_reg;
    assign nst       = ign_reg ? 3'd4 : 3'd5;
    assign site_last = ({1'b0, site_reg} == npos_eff - 11'd1);
    assign z_last    = (z_reg == nst - 3'd1);

    always_comb begin
        inc_word = rd_a;
        if (rd_a[add_idx_reg] != {afd_pkg::COUNT_BITS{1'b1}}) begin
            inc_word[add_idx_reg] = rd_a[add_idx_reg] + 1'b1;
        end
    end

    always_comb begin
        mem_req.rd_en     = (s_fire && s_data.op == afd_pkg::OP_ADD && bcode.hit) ||
                            (state_reg == S_Q_RD);
        mem_req.rd_addr_a = (state_reg == S_Q_RD) ? {qa_reg, site_reg} :
                                                    {s_data.org_a, s_data.site};
        mem_req.rd_addr_b = {qb_reg, site_reg};
        mem_req.wr_en     = (state_reg == S_CLEAR) || (state_reg == S_ADD_WR);
        mem_req.wr_addr   = (state_reg == S_CLEAR) ? clr_addr_reg : add_addr_reg;
        mem_req.wr_data   = (state_reg == S_CLEAR) ? '0 : inc_word;
    end

    assign iq_start = (state_reg == S_N_SQS) || (state_reg == S_FIN && !method_reg);
    assign iq_rad   = (state_reg == S_N_SQS) ? AW'(prod_reg) : acc_reg;

    assign fd_trial = {fd_rem_reg, fd_quo_reg[AW-1]};
    assign fd_ge    = (fd_trial >= {1'b0, npos_eff});
    assign nei_term = (nsum_reg >= NEI_ONE) ? '0 : FW'(NEI_ONE - nsum_reg);

    afd_count_mem u_mem (
        .aclk (aclk),
        .req  (mem_req),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    afd_freq_div u_div (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (state_reg == S_Q_LOAD),
        .ignore_missing (ign_reg),
        .cnt_a          (rd_a),
        .cnt_b          (rd_b),
        .busy           (fd_busy),
        .freq_a         (fa),
        .freq_b         (fb)
    );

    afd_isqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (iq_start),
        .radicand (iq_rad),
        .busy     (iq_busy),
        .root     (iq_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg <= 1'b0;
            ign_reg    <= 1'b1;
            norg_reg   <= afd_pkg::NORG_W'(64);
            npos_reg   <= afd_pkg::NPOS_W'(1024);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                afd_pkg::CFG_METHOD:  method_reg <= cfg_data[0];
                afd_pkg::CFG_IGNORE:  ign_reg    <= cfg_data[0];
                afd_pkg::CFG_NUM_ORG: norg_reg   <= cfg_data[afd_pkg::NORG_W-1:0];
                afd_pkg::CFG_NUM_POS: npos_reg   <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            present_reg  <= '0;
        end else begin
            unique case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == {afd_pkg::ADDR_W{1'b1}}) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_fire) begin
                        case (s_data.op)
                            afd_pkg::OP_ADD: begin
                                present_reg[s_data.org_a] <= 1'b1;
                                add_addr_reg <= {s_data.org_a, s_data.site};
                                add_idx_reg  <= bcode.idx;
                                if (bcode.hit) begin
                                    state_reg <= S_ADD_WR;
                                end
                            end
                            afd_pkg::OP_CLEAR: begin
                                present_reg  <= '0;
                                clr_addr_reg <= '0;
                                state_reg    <= S_CLEAR;
                            end
                            afd_pkg::OP_QUERY: begin
                                qa_reg       <= s_data.org_a;
                                qb_reg       <= s_data.org_b;
                                site_reg     <= '0;
                                acc_reg      <= '0;
                                res_dist_reg <= '0;
                                res_miss_reg <= 1'b0;
                                state_reg    <= S_OUT;
                                if ({1'b0, s_data.org_a} >= norg_eff ||
                                    {1'b0, s_data.org_b} >= norg_eff) begin
                                    res_miss_reg <= 1'b1;
                                end else if (s_data.org_a == s_data.org_b) begin
                                    res_miss_reg <= 1'b0;
                                end else if (!present_reg[s_data.org_a] ||
                                             !present_reg[s_data.org_b]) begin
                                    res_miss_reg <= 1'b1;
                                end else if (npos_eff != '0) begin
                                    state_reg <= S_Q_RD;
                                end
                            end
                            default: begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_ADD_WR: state_reg <= S_IDLE;
                S_Q_RD:   state_reg <= S_Q_LOAD;
                S_Q_LOAD: begin
                    z_reg     <= '0;
                    nsum_reg  <= '0;
                    state_reg <= S_Q_DIV;
                end
                S_Q_DIV: begin
                    if (!fd_busy) begin
                        state_reg <= method_reg ? S_N_MUL : S_E_DIF;
                    end
                end
                S_E_DIF: begin
                    diff_reg  <= (fa[z_reg] >= fb[z_reg]) ? fa[z_reg] - fb[z_reg] :
                                                            fb[z_reg] - fa[z_reg];
                    state_reg <= S_E_MUL;
                end
                S_E_MUL: begin
                    prod_reg  <= diff_reg * diff_reg;
                    state_reg <= S_E_ACC;
                end
                S_E_ACC: begin
                    acc_reg <= acc_add(acc_reg, AW'(prod_reg));
                    z_reg   <= z_reg + 3'd1;
                    if (!z_last) begin
                        state_reg <= S_E_DIF;
                    end else if (site_last) begin
                        state_reg <= S_FIN;
                    end else begin
                        site_reg  <= site_reg + 1'b1;
                        state_reg <= S_Q_RD;
                    end
                end
                S_N_MUL: begin
                    prod_reg  <= fa[z_reg] * fb[z_reg];
                    state_reg <= S_N_SQS;
                end
                S_N_SQS: state_reg <= S_N_SQW;
                S_N_SQW: begin
                    if (!iq_busy) begin
                        nsum_reg <= nsum_reg + NSW'(iq_root);
                        z_reg    <= z_reg + 3'd1;
                        state_reg <= z_last ? S_N_ACC : S_N_MUL;
                    end
                end
                S_N_ACC: begin
                    acc_reg <= acc_add(acc_reg, AW'(nei_term));
                    if (site_last) begin
                        state_reg <= S_FIN;
                    end else begin
                        site_reg  <= site_reg + 1'b1;
                        state_reg <= S_Q_RD;
                    end
                end
                S_FIN: begin
                    fd_rem_reg  <= '0;
                    fd_quo_reg  <= acc_reg;
                    fd_step_reg <= '0;
                    state_reg   <= S_FIN_W;
                end
                S_FIN_W: begin
                    if (!method_reg) begin
                        if (!iq_busy) begin
                            res_dist_reg <= iq_root;
                            state_reg    <= S_OUT;
                        end
                    end else if (fd_step_reg == FD_LAST) begin
                        res_dist_reg <= (fd_quo_reg[AW-1:afd_pkg::DIST_W] != '0) ?
                                        {afd_pkg::DIST_W{1'b1}} :
                                        fd_quo_reg[afd_pkg::DIST_W-1:0];
                        state_reg    <= S_OUT;
                    end else begin
                        fd_rem_reg  <= fd_ge ? afd_pkg::TOTAL_W'(fd_trial - {1'b0, npos_eff}) :
                                               fd_trial[afd_pkg::TOTAL_W-1:0];
                        fd_quo_reg  <= {fd_quo_reg[AW-2:0], fd_ge};
                        fd_step_reg <= fd_step_reg + 6'd1;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.distance    <= res_dist_reg;
            m_data_reg.org_missing <= res_miss_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_clear_sweeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.op == afd_pkg::OP_CLEAR) |=> (state_reg == S_CLEAR))
        else $error("clear beat did not start the sweep");

    a_div_in_query: assert property (@(posedge aclk) disable iff (!aresetn)
        fd_busy |-> (state_reg == S_Q_DIV))
        else $error("frequency divider busy outside its wait state");

    a_missing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.org_missing) |-> (m_data_reg.distance == '0))
        else $error("missing organism with nonzero distance");

    a_no_wr_on_query_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_Q_RD) |-> !mem_req.wr_en)
        else $error("memory write during query read");

endmodule

>>> dv/allele_frequency_distance_checker.sv
// Checker for the allele frequency distance block: tracks counts, predicts query distances.
module allele_frequency_distance_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  afd_pkg::in_beat_t             s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  afd_pkg::out_beat_t            m_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [afd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [afd_pkg::NPOS_W-1:0]    cfg_data,
    output int                            errors,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned ONE_FX   = 64'd1 << afd_pkg::FRAC_BITS;
    localparam longint unsigned ACC_SAT  = (64'd1 << afd_pkg::ACC_W) - 1;
    localparam longint unsigned DIST_SAT = (64'd1 << afd_pkg::DIST_W) - 1;

    logic [afd_pkg::COUNT_BITS-1:0] allele_cnt [afd_pkg::MAX_ORGS*afd_pkg::MAX_SITES*
                                                afd_pkg::NUM_STATES];
    logic                           org_seen   [afd_pkg::MAX_ORGS];
    logic                           use_nei;
    logic                           skip_gap;
    logic [afd_pkg::NORG_W-1:0]     orgs_used;
    logic [afd_pkg::NPOS_W-1:0]     sites_used;
    afd_pkg::out_beat_t             distance_q [$];

    function automatic int slot(int org, int site, int st);
        return (org * afd_pkg::MAX_SITES + site) * afd_pkg::NUM_STATES + st;
    endfunction

    function automatic longint unsigned int_root(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned rel_freq(int org, int site, int st, int nst);
        longint unsigned total;
        total = 0;
        for (int z = 0; z < nst; z++) total += allele_cnt[slot(org, site, z)];
        if (st >= nst || total == 0) return 0;
        return (longint'(allele_cnt[slot(org, site, st)]) << afd_pkg::FRAC_BITS) / total;
    endfunction

    function automatic longint unsigned pair_distance(int a, int b, int npos);
        longint unsigned acc;
        longint unsigned fa;
        longint unsigned fb;
        longint unsigned d;
        longint unsigned rs;
        int nst;
        acc = 0;
        nst = skip_gap ? 4 : 5;
        for (int w = 0; w < npos; w++) begin
            rs = 0;
            for (int z = 0; z < nst; z++) begin
                fa = rel_freq(a, w, z, nst);
                fb = rel_freq(b, w, z, nst);
                if (!use_nei) begin
                    d = (fa >= fb) ? fa - fb : fb - fa;
                    acc = (acc + d * d > ACC_SAT) ? ACC_SAT : acc + d * d;
                end else begin
                    rs += int_root(fa * fb);
                end
            end
            if (use_nei) begin
                d = (rs >= ONE_FX) ? 0 : ONE_FX - rs;
                acc = (acc + d > ACC_SAT) ? ACC_SAT : acc + d;
            end
        end
        d = use_nei ? acc / npos : int_root(acc);
        return (d > DIST_SAT) ? DIST_SAT : d;
    endfunction

    function automatic afd_pkg::out_beat_t query_result(int a, int b);
        afd_pkg::out_beat_t r;
        int norg;
        int npos;
        r = '0;
        norg = (orgs_used > afd_pkg::MAX_ORGS) ? afd_pkg::MAX_ORGS : orgs_used;
        npos = (sites_used > afd_pkg::MAX_SITES) ? afd_pkg::MAX_SITES : sites_used;
        if (a >= norg || b >= norg) r.org_missing = 1'b1;
        else if (a == b) r = '0;
        else if (!org_seen[a] || !org_seen[b]) r.org_missing = 1'b1;
        else if (npos != 0) r.distance = afd_pkg::DIST_W'(pair_distance(a, b, npos));
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic wipe();
        foreach (allele_cnt[i]) allele_cnt[i] = '0;
        foreach (org_seen[i]) org_seen[i] = 1'b0;
    endtask

    initial begin
        errors = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        int st;
        int k;
        afd_pkg::out_beat_t want;
        if (!aresetn) begin
            wipe();
            use_nei    = 1'b0;
            skip_gap   = 1'b1;
            orgs_used  = 7'd64;
            sites_used = 11'd1024;
            distance_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    afd_pkg::CFG_METHOD:  use_nei    = cfg_data[0];
                    afd_pkg::CFG_IGNORE:  skip_gap   = cfg_data[0];
                    afd_pkg::CFG_NUM_ORG: orgs_used  = cfg_data[afd_pkg::NORG_W-1:0];
                    afd_pkg::CFG_NUM_POS: sites_used = cfg_data;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_data.op)
                    afd_pkg::OP_ADD: begin
                        org_seen[s_data.org_a] = 1'b1;
                        st = -1;
                        case (s_data.base)
                            afd_pkg::CHAR_A:   st = 0;
                            afd_pkg::CHAR_C:   st = 1;
                            afd_pkg::CHAR_T:   st = 2;
                            afd_pkg::CHAR_G:   st = 3;
                            afd_pkg::CHAR_GAP: st = 4;
                            default:           st = -1;
                        endcase
                        if (st >= 0) begin
                            k = slot(s_data.org_a, s_data.site, st);
                            if (allele_cnt[k] != '1) allele_cnt[k]++;
                        end
                    end
                    afd_pkg::OP_CLEAR: wipe();
                    afd_pkg::OP_QUERY:
                        distance_q.insert(distance_q.size(),
                                          query_result(s_data.org_a, s_data.org_b));
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (distance_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $realtime);
                    errors++;
                end else begin
                    want = distance_q.pop_front();
                    if (m_data.distance !== want.distance)
                        report("distance", m_data.distance, want.distance);
                    if (m_data.org_missing !== want.org_missing)
                        report("org_missing", m_data.org_missing, want.org_missing);
                end
            end
        end
        pending = distance_q.size();
    end

endmodule

>>> dv/allele_frequency_distance_tb.sv
// Testbench top for the allele frequency distance block: stimulus, flow control and verdict.
module allele_frequency_distance_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    afd_pkg::in_beat_t             s_data;
    logic                          m_valid;
    logic                          m_ready;
    afd_pkg::out_beat_t            m_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [afd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [afd_pkg::NPOS_W-1:0]    cfg_data;
    int                            errors;
    int                            pending;
    bit                            gaps_on = 1'b1;
    int                            ready_pct = 70;
    bit                            long_hold = 1'b0;

    always #1 aclk = ~aclk;

    allele_frequency_distance i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    allele_frequency_distance_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    function automatic afd_pkg::in_beat_t beat(afd_pkg::op_t op, int a, int b, int site,
                                               int ch);
        afd_pkg::in_beat_t x;
        x.op = op;
        x.org_a = afd_pkg::ORG_W'(a);
        x.org_b = afd_pkg::ORG_W'(b);
        x.site = afd_pkg::SITE_W'(site);
        x.base = 8'(ch);
        return x;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    task automatic push(input afd_pkg::in_beat_t x);
        int g;
        g = pick_gap();
        if (gaps_on && g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= x;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (300) @(posedge aclk);
    endtask

    task automatic set_config(input int meth, input int ign, input int norg, input int npos);
        logic [afd_pkg::NPOS_W-1:0] vals [4];
        logic [afd_pkg::CFG_IDX_W-1:0] idx [4];
        vals = '{afd_pkg::NPOS_W'(meth), afd_pkg::NPOS_W'(ign),
                 afd_pkg::NPOS_W'(norg), afd_pkg::NPOS_W'(npos)};
        idx  = '{afd_pkg::CFG_METHOD, afd_pkg::CFG_IGNORE,
                 afd_pkg::CFG_NUM_ORG, afd_pkg::CFG_NUM_POS};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] any_base();
        case ($urandom_range(0, 6))
            0: return afd_pkg::CHAR_A;
            1: return afd_pkg::CHAR_C;
            2: return afd_pkg::CHAR_T;
            3: return afd_pkg::CHAR_G;
            4: return afd_pkg::CHAR_GAP;
            5: return afd_pkg::CHAR_A;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic afd_pkg::in_beat_t random_beat(int pool, int smax, int qpct);
        int r;
        int a;
        int b;
        r = $urandom_range(0, 99);
        if (r < qpct) begin
            a = ($urandom_range(0, 99) < 85) ? $urandom_range(0, pool - 1) : $urandom_range(0, 63);
            b = ($urandom_range(0, 99) < 85) ? $urandom_range(0, pool - 1) : $urandom_range(0, 63);
            if ($urandom_range(0, 9) == 0) b = a;
            return beat(afd_pkg::OP_QUERY, a, b, $urandom_range(0, 1023),
                        $urandom_range(0, 255));
        end
        if (r < qpct + 2)
            return beat(afd_pkg::OP_NOP, $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 1023), $urandom_range(0, 255));
        a = ($urandom_range(0, 9) != 0) ? $urandom_range(0, pool - 1) : $urandom_range(0, 63);
        return beat(afd_pkg::OP_ADD, a, $urandom_range(0, 63),
                    ($urandom_range(0, 9) != 0) ? $urandom_range(0, smax)
                                                : $urandom_range(0, 1023),
                    any_base());
    endfunction

    initial begin : sink
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
                long_hold = 1'b0;
            end else if ($urandom_range(0, 199) == 0 && ready_pct < 100) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(100, 400)) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    initial begin : stimulus
        int meth [10] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
        int ign  [10] = '{1, 0, 0, 1, 1, 0, 0, 1, 1, 0};
        int norg [10] = '{64, 8, 1, 100, 0, 64, 127, 16, 64, 2};
        int npos [10] = '{3, 5, 2, 1, 4, 0, 8, 6, 2047, 1};
        int count;
        int pool;
        int smax;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        set_config(0, 1, 64, 4);
        push(beat(afd_pkg::OP_ADD, 0, 0, 0, afd_pkg::CHAR_A));
        push(beat(afd_pkg::OP_ADD, 0, 0, 0, afd_pkg::CHAR_C));
        push(beat(afd_pkg::OP_ADD, 0, 0, 1, afd_pkg::CHAR_G));
        push(beat(afd_pkg::OP_ADD, 1, 0, 0, afd_pkg::CHAR_T));
        push(beat(afd_pkg::OP_ADD, 1, 0, 1, afd_pkg::CHAR_GAP));
        push(beat(afd_pkg::OP_ADD, 1, 0, 2, 8'h78));
        push(beat(afd_pkg::OP_ADD, 63, 63, 1023, afd_pkg::CHAR_A));
        push(beat(afd_pkg::OP_ADD, 63, 0, 3, afd_pkg::CHAR_G));
        push(beat(afd_pkg::OP_ADD, 2, 0, 3, 8'hFF));
        push(beat(afd_pkg::OP_QUERY, 0, 1, 0, 0));
        push(beat(afd_pkg::OP_QUERY, 0, 0, 0, 0));
        push(beat(afd_pkg::OP_QUERY, 5, 5, 0, 0));
        push(beat(afd_pkg::OP_QUERY, 0, 5, 0, 0));
        push(beat(afd_pkg::OP_QUERY, 63, 0, 0, 0));
        push(beat(afd_pkg::OP_QUERY, 2, 63, 0, 0));
        push(beat(afd_pkg::OP_NOP, 63, 63, 1023, 8'hFF));
        drain();
        set_config(1, 0, 64, 4);
        push(beat(afd_pkg::OP_QUERY, 0, 1, 0, 0));
        push(beat(afd_pkg::OP_QUERY, 1, 63, 0, 0));
        push(beat(afd_pkg::OP_QUERY, 2, 0, 0, 0));
        push(beat(afd_pkg::OP_CLEAR, 0, 0, 0, 0));
        push(beat(afd_pkg::OP_QUERY, 0, 1, 0, 0));
        drain();

        for (int p = 0; p < 10; p++) begin
            set_config(meth[p], ign[p], norg[p], npos[p]);
            gaps_on   = (p % 2 == 0);
            ready_pct = (p % 3 == 2) ? 100 : $urandom_range(40, 90);
            pool = (norg[p] < 4) ? 3 : 10;
            smax = (npos[p] == 0) ? 0 : ((npos[p] > 1024) ? 1023 : npos[p] - 1);
            if (p == 1) long_hold = 1'b1;
            if (p == 2 || p == 6) push(beat(afd_pkg::OP_CLEAR, 0, 0, 0, 0));
            if (p == 0)
                repeat (260) push(beat(afd_pkg::OP_ADD, 3, 0, 1, afd_pkg::CHAR_T));
            count = (p == 8) ? 60 : 170;
            if (p == 0) count = 0;
            for (int i = 0; i < count; i++)
                push(random_beat(pool, smax, (p == 8) ? 0 : 20));
            if (p == 8) begin
                push(beat(afd_pkg::OP_QUERY, 0, 1, 0, 0));
                push(beat(afd_pkg::OP_QUERY, 1, 2, 0, 0));
            end
            if (p == 0) begin
                for (int i = 0; i < 140; i++)
                    push(random_beat(pool, smax, 20));
                push(beat(afd_pkg::OP_QUERY, 3, 0, 0, 0));
            end
            drain();
        end

        if (errors == 0) begin
            $display("allele_frequency_distance_tb: done, clean");
        end else begin
            $display("allele_frequency_distance_tb: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("allele_frequency_distance_tb: done, errors");
        $finish;
    end

endmodule
